// ----- rtl/peer_signal_table_unit_macros.svh -----
// Assertion macros for the peer signal table unit.
// Used by the port checker; expects clk and arst_n in scope.
`ifndef PEER_SIGNAL_TABLE_UNIT_MACROS_SVH
`define PEER_SIGNAL_TABLE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PST_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("peer signal table check failed");

// The consequent must hold in the cycle after the antecedent.
`define PST_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("peer signal table check failed");

`endif

// ----- rtl/pst_pkg.sv -----
// Shared types, constants and helper functions for the peer signal table unit.
// Used by every module of the block; depends on nothing else.
package pst_pkg;

	localparam int TABLE_SLOTS = 16;
	localparam int MAP_ENTRIES = 1025;
	localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int MAP_AW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;

	localparam int KIND_W = 2;
	localparam int ADDR_W = 16;
	localparam int ENERGY_W = 8;
	localparam int LIFE_W = 8;
	localparam int LEVEL_W = 9;
	localparam int PING_W = 7;
	localparam int SLOT_FIELD_W = 4;
	localparam int S_TDATA_W = 24;
	localparam int OUT_FIELDS_W = 25;
	localparam int M_TDATA_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 9;

	localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

	// Register indexes on the configuration channel.
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_HUG = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_CLOSE = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_SLOW = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_MID = CFG_IDX_W'(5);
	localparam logic [CFG_IDX_W-1:0] REG_FAST = CFG_IDX_W'(6);

	// Register values after reset.
	localparam logic ENABLE_RST = 1'b1;
	localparam logic [LIFE_W-1:0] TIMEOUT_RST = LIFE_W'(128);
	localparam logic [LEVEL_W-1:0] HUG_RST = LEVEL_W'(80);
	localparam logic [ENERGY_W-1:0] CLOSE_RST = ENERGY_W'(15);
	localparam logic [PING_W-1:0] SLOW_RST = PING_W'(64);
	localparam logic [PING_W-1:0] MID_RST = PING_W'(32);
	localparam logic [PING_W-1:0] FAST_RST = PING_W'(4);

	typedef enum logic [KIND_W-1:0] {
		KIND_PACKET = 2'd0,
		KIND_TICK = 2'd1,
		KIND_MARK = 2'd2
	} kind_t;

	typedef struct packed {
		logic start;
		logic pkt_step;
		logic tick_step;
		logic clr_step;
		logic commit;
	} pst_cmd_t;

	typedef struct packed {
		logic enable;
		logic idx_last;
		logic hit;
		logic clr_last;
		logic out_free;
	} pst_status_t;

	function automatic logic [SLOT_FIELD_W-1:0] slot_field(input logic [SLOT_W-1:0] idx);
		logic [SLOT_W+SLOT_FIELD_W-1:0] wide;
		wide = {{SLOT_FIELD_W{1'b0}}, idx};
		return wide[SLOT_FIELD_W-1:0];
	endfunction

	function automatic logic in_map(input logic [ADDR_W-1:0] addr);
		return ({1'b0, addr} < (ADDR_W+1)'(MAP_ENTRIES));
	endfunction

endpackage

// ----- rtl/pst_map.sv -----
// Contacted-peer map: one bit per address, one write and one read port.
// Depends on pst_pkg for its depth and address width.
module pst_map (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [pst_pkg::MAP_AW-1:0] wr_addr,
	input  logic                      wr_data,
	input  logic                      rd_en,
	input  logic [pst_pkg::MAP_AW-1:0] rd_addr,
	output logic                      rd_data
);

	logic mem_q [pst_pkg::MAP_ENTRIES];
	logic rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/pst_dp.sv -----
// Datapath of the peer signal table: configuration, slot table, scan unit,
// tick accumulators and the output register. Depends on pst_pkg.
module pst_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pst_pkg::pst_cmd_t               cmd,
	output pst_pkg::pst_status_t            st,
	input  logic [pst_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic [pst_pkg::KIND_W-1:0]      s_tuser,
	input  logic                            cfg_wr,
	input  logic [pst_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pst_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [pst_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic                            map_wr_en,
	output logic [pst_pkg::MAP_AW-1:0]      map_wr_addr,
	output logic                            map_wr_data,
	output logic                            map_rd_en,
	output logic [pst_pkg::MAP_AW-1:0]      map_rd_addr,
	input  logic                            map_rd_data
);

	// Configuration registers.
	logic                              enable_q;
	logic [pst_pkg::LIFE_W-1:0]        timeout_q;
	logic [pst_pkg::LEVEL_W-1:0]       hug_level_q;
	logic [pst_pkg::ENERGY_W-1:0]      close_level_q;
	logic [pst_pkg::PING_W-1:0]        slow_q;
	logic [pst_pkg::PING_W-1:0]        mid_q;
	logic [pst_pkg::PING_W-1:0]        fast_q;

	// Slot table.
	logic [pst_pkg::ADDR_W-1:0]        tab_addr_q   [pst_pkg::TABLE_SLOTS];
	logic [pst_pkg::LIFE_W-1:0]        tab_life_q   [pst_pkg::TABLE_SLOTS];
	logic [pst_pkg::ENERGY_W-1:0]      tab_enow_q   [pst_pkg::TABLE_SLOTS];
	logic [pst_pkg::ENERGY_W-1:0]      tab_ebef_q   [pst_pkg::TABLE_SLOTS];

	// Current item.
	pst_pkg::kind_t                    kind_q;
	logic [pst_pkg::ADDR_W-1:0]        addr_q;
	logic [pst_pkg::ENERGY_W-1:0]      energy_q;

	// Scan state.
	logic [pst_pkg::SLOT_W-1:0]        idx_q;
	logic                              found_q;
	logic [pst_pkg::SLOT_W-1:0]        pick_q;
	logic [pst_pkg::ENERGY_W-1:0]      pick_e_q;
	logic [pst_pkg::ENERGY_W-1:0]      min_e_q;
	logic [pst_pkg::SLOT_W-1:0]        min_i_q;
	logic                              live_q;
	logic                              close_q;
	logic                              um_live_q;
	logic                              um_close_q;
	logic                              hug_q;
	logic [pst_pkg::ADDR_W-1:0]        hug_a_q;
	logic [pst_pkg::PING_W-1:0]        ping_q;
	logic [pst_pkg::MAP_AW-1:0]        clr_q;

	// Tick pipeline stage, waiting for the map read.
	logic                              v_s1;
	logic                              life_nz_s1;
	logic                              inmap_s1;
	logic [pst_pkg::ENERGY_W-1:0]      enow_s1;

	logic                              m_tvalid_q;
	logic [pst_pkg::M_TDATA_W-1:0]     m_tdata_q;

	// Current slot and derived terms.
	logic [pst_pkg::ADDR_W-1:0]        cur_addr;
	logic [pst_pkg::LIFE_W-1:0]        cur_life;
	logic [pst_pkg::ENERGY_W-1:0]      cur_enow;
	logic [pst_pkg::ENERGY_W-1:0]      cur_ebef;
	logic                              cur_match;
	logic                              cur_free;
	logic [pst_pkg::LEVEL_W-1:0]       cur_sum;
	logic                              table_clear;
	logic                              pkt_ok;
	logic                              tick_ok;
	logic                              mark_ok;
	logic                              pkt_take;
	logic [pst_pkg::SLOT_W-1:0]        pick_sel;
	logic [pst_pkg::ENERGY_W-1:0]      pick_e_sel;
	logic [pst_pkg::PING_W-1:0]        ping_inc;
	logic                              ping_due;
	logic                              marked_s1;
	logic [pst_pkg::OUT_FIELDS_W-1:0]  res_fields;

	assign cur_addr  = tab_addr_q[idx_q];
	assign cur_life  = tab_life_q[idx_q];
	assign cur_enow  = tab_enow_q[idx_q];
	assign cur_ebef  = tab_ebef_q[idx_q];
	assign cur_match = (cur_addr == addr_q);
	assign cur_free  = (cur_life == '0);
	assign cur_sum   = {1'b0, cur_enow} + {1'b0, cur_ebef};

	assign table_clear = cfg_wr && (cfg_index == pst_pkg::REG_ENABLE) && cfg_data[0];

	assign pkt_ok  = enable_q && (kind_q == pst_pkg::KIND_PACKET);
	assign tick_ok = enable_q && (kind_q == pst_pkg::KIND_TICK);
	assign mark_ok = (kind_q == pst_pkg::KIND_MARK) && pst_pkg::in_map(addr_q);

	// Without a match or a free slot, min_e_q is the energy of the eviction victim.
	assign pkt_take   = pkt_ok && (found_q || (energy_q > min_e_q));
	assign pick_sel   = found_q ? pick_q : min_i_q;
	assign pick_e_sel = found_q ? pick_e_q : min_e_q;

	assign ping_inc = ping_q + 1'b1;
	assign ping_due = (ping_inc > slow_q) || (live_q && (ping_inc > mid_q)) ||
		(close_q && (ping_inc > fast_q));

	// An address beyond the map counts as already contacted.
	assign marked_s1 = !inmap_s1 || map_rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= pst_pkg::ENABLE_RST;
			timeout_q     <= pst_pkg::TIMEOUT_RST;
			hug_level_q   <= pst_pkg::HUG_RST;
			close_level_q <= pst_pkg::CLOSE_RST;
			slow_q        <= pst_pkg::SLOW_RST;
			mid_q         <= pst_pkg::MID_RST;
			fast_q        <= pst_pkg::FAST_RST;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				pst_pkg::REG_ENABLE:  enable_q      <= cfg_data[0];
				pst_pkg::REG_TIMEOUT: timeout_q     <= cfg_data[pst_pkg::LIFE_W-1:0];
				pst_pkg::REG_HUG:     hug_level_q   <= cfg_data[pst_pkg::LEVEL_W-1:0];
				pst_pkg::REG_CLOSE:   close_level_q <= cfg_data[pst_pkg::ENERGY_W-1:0];
				pst_pkg::REG_SLOW:    slow_q        <= cfg_data[pst_pkg::PING_W-1:0];
				pst_pkg::REG_MID:     mid_q         <= cfg_data[pst_pkg::PING_W-1:0];
				pst_pkg::REG_FAST:    fast_q        <= cfg_data[pst_pkg::PING_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pst_pkg::TABLE_SLOTS; i++) begin
				tab_addr_q[i] <= '0;
				tab_life_q[i] <= '0;
				tab_enow_q[i] <= '0;
				tab_ebef_q[i] <= '0;
			end
		end else if (table_clear) begin
			for (int i = 0; i < pst_pkg::TABLE_SLOTS; i++) begin
				tab_addr_q[i] <= '0;
				tab_life_q[i] <= '0;
				tab_enow_q[i] <= '0;
				tab_ebef_q[i] <= '0;
			end
		end else begin
			if (cmd.tick_step && !cur_free) begin
				tab_life_q[idx_q] <= cur_life - 1'b1;
			end
			if (cmd.commit && pkt_take) begin
				tab_life_q[pick_sel] <= timeout_q;
				tab_addr_q[pick_sel] <= addr_q;
				tab_ebef_q[pick_sel] <= pick_e_sel;
				tab_enow_q[pick_sel] <= energy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			kind_q   <= pst_pkg::kind_t'(s_tuser);
			addr_q   <= s_tdata[pst_pkg::ADDR_W-1:0];
			energy_q <= s_tdata[pst_pkg::ADDR_W +: pst_pkg::ENERGY_W];
		end
		if (cmd.tick_step) begin
			life_nz_s1 <= !cur_free;
			inmap_s1   <= pst_pkg::in_map(cur_addr);
			enow_s1    <= cur_enow;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			found_q    <= 1'b0;
			pick_q     <= '0;
			pick_e_q   <= '0;
			min_e_q    <= pst_pkg::ENERGY_MAX;
			min_i_q    <= '0;
			live_q     <= 1'b0;
			close_q    <= 1'b0;
			um_live_q  <= 1'b0;
			um_close_q <= 1'b0;
			hug_q      <= 1'b0;
			hug_a_q    <= '0;
			ping_q     <= '0;
			clr_q      <= '0;
			v_s1       <= 1'b0;
		end else begin
			v_s1 <= cmd.tick_step;
			if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.start) begin
				idx_q      <= '0;
				found_q    <= 1'b0;
				min_e_q    <= pst_pkg::ENERGY_MAX;
				min_i_q    <= '0;
				live_q     <= 1'b0;
				close_q    <= 1'b0;
				um_live_q  <= 1'b0;
				um_close_q <= 1'b0;
				hug_q      <= 1'b0;
				hug_a_q    <= '0;
			end
			if (cmd.pkt_step) begin
				idx_q <= idx_q + 1'b1;
				if (cur_match || cur_free) begin
					// A free slot has its history dropped before it is taken.
					found_q  <= 1'b1;
					pick_q   <= idx_q;
					pick_e_q <= cur_match ? cur_enow : '0;
				end else if (cur_enow < min_e_q) begin
					min_e_q <= cur_enow;
					min_i_q <= idx_q;
				end
			end
			if (cmd.tick_step) begin
				idx_q <= idx_q + 1'b1;
				if (!hug_q && (cur_addr != '0) && (cur_sum > hug_level_q)) begin
					hug_q   <= 1'b1;
					hug_a_q <= cur_addr;
				end
			end
			if (v_s1 && life_nz_s1) begin
				live_q <= 1'b1;
				if (!marked_s1) begin
					um_live_q <= 1'b1;
				end
				if (enow_s1 > close_level_q) begin
					close_q <= 1'b1;
					if (!marked_s1) begin
						um_close_q <= 1'b1;
					end
				end
			end
			if (cmd.commit && tick_ok) begin
				ping_q <= ping_due ? '0 : ping_inc;
			end
		end
	end

	assign res_fields = {
		tick_ok ? hug_a_q : {pst_pkg::ADDR_W{1'b0}},
		tick_ok && hug_q,
		tick_ok && um_close_q,
		tick_ok && um_live_q,
		tick_ok && ping_due,
		pkt_take ? pst_pkg::slot_field(pick_sel) : {pst_pkg::SLOT_FIELD_W{1'b0}},
		pkt_take
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			m_tdata_q <= {{(pst_pkg::M_TDATA_W - pst_pkg::OUT_FIELDS_W){1'b0}}, res_fields};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign map_wr_en   = cmd.clr_step || (cmd.commit && mark_ok);
	assign map_wr_addr = cmd.clr_step ? clr_q : addr_q[pst_pkg::MAP_AW-1:0];
	assign map_wr_data = !cmd.clr_step;
	assign map_rd_en   = cmd.tick_step;
	assign map_rd_addr = cur_addr[pst_pkg::MAP_AW-1:0];

	assign st.enable   = enable_q;
	assign st.idx_last = (idx_q == pst_pkg::SLOT_W'(pst_pkg::TABLE_SLOTS - 1));
	assign st.hit      = cur_match || cur_free;
	assign st.clr_last = (clr_q == pst_pkg::MAP_AW'(pst_pkg::MAP_ENTRIES - 1));
	assign st.out_free = !m_tvalid_q || m_tready;

endmodule

// ----- rtl/pst_ctrl.sv -----
// Controller of the peer signal table: sequences the map clearing pass,
// the packet and tick scans and the hand-over of each result. Depends on pst_pkg.
module pst_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [pst_pkg::KIND_W-1:0]  s_tuser,
	input  pst_pkg::pst_status_t        st,
	output pst_pkg::pst_cmd_t           cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PSCAN,
		ST_TSCAN,
		ST_TDRAIN,
		ST_RESULT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (st.clr_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						if (!st.enable) begin
							state_q <= ST_RESULT;
						end else begin
							unique case (s_tuser)
								pst_pkg::KIND_PACKET: state_q <= ST_PSCAN;
								pst_pkg::KIND_TICK:   state_q <= ST_TSCAN;
								default:              state_q <= ST_RESULT;
							endcase
						end
					end
				end
				ST_PSCAN: begin
					if (st.hit || st.idx_last) begin
						state_q <= ST_RESULT;
					end
				end
				ST_TSCAN: begin
					if (st.idx_last) begin
						state_q <= ST_TDRAIN;
					end
				end
				// The last slot's map bit arrives here.
				ST_TDRAIN: state_q <= ST_RESULT;
				ST_RESULT: begin
					if (st.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_CLEAR:  cmd.clr_step  = 1'b1;
			ST_IDLE:   cmd.start     = s_tvalid;
			ST_PSCAN:  cmd.pkt_step  = 1'b1;
			ST_TSCAN:  cmd.tick_step = 1'b1;
			ST_TDRAIN: ;
			ST_RESULT: cmd.commit    = st.out_free;
			default: ;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);

endmodule

// ----- rtl/peer_signal_table_unit.sv -----
// Top level of the peer signal table unit.
// Instantiates pst_ctrl, pst_dp and pst_map; depends on pst_pkg.
//
// Input words arrive on s_tvalid/s_tready: s_tuser carries the kind (packet,
// tick or mark) and s_tdata the peer address and energy. Every input word
// yields exactly one output word on m_tvalid/m_tready.
// Registers are written on cfg_valid/cfg_ready (always ready) with cfg_index
// and cfg_data; the user must see that they are written only while the block
// is idle, which the block itself does not enforce. Writing 1 to enable
// clears the slot table. A packet scans the slots one a cycle until a match
// or a free slot turns up. A tick scans every slot, one a cycle, with the
// contacted-map read pipelined one stage behind. Marks, disabled items and
// unused kinds go straight from idle to the result state. One item is in
// work at a time.
// After reset the contacted map is cleared one entry a cycle, all MAP_ENTRIES
// (1025) entries, during which no input word is taken; configuration writes
// are taken throughout.
// A finished word waits in the output register while the next input word is
// accepted and worked on; that item then holds until the receiver takes it.
module peer_signal_table_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [pst_pkg::S_TDATA_W-1:0]   s_tdata,  // peer_addr[15:0], energy[23:16]
	input  logic [pst_pkg::KIND_W-1:0]      s_tuser,  // kind[1:0]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// accepted[0], slot[4:1], ping_due[5], unmarked_in_range[6],
	// unmarked_close[7], hug_found[8], hug_addr[24:9], zeros above
	output logic [pst_pkg::M_TDATA_W-1:0]   m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pst_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pst_pkg::CFG_DATA_W-1:0]  cfg_data
);

	pst_pkg::pst_cmd_t            cmd;
	pst_pkg::pst_status_t         st;
	logic                         map_wr_en;
	logic [pst_pkg::MAP_AW-1:0]   map_wr_addr;
	logic                         map_wr_data;
	logic                         map_rd_en;
	logic [pst_pkg::MAP_AW-1:0]   map_rd_addr;
	logic                         map_rd_data;

	assign cfg_ready = 1'b1;

	pst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.st       (st),
		.cmd      (cmd)
	);

	pst_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.cfg_wr      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.map_wr_en   (map_wr_en),
		.map_wr_addr (map_wr_addr),
		.map_wr_data (map_wr_data),
		.map_rd_en   (map_rd_en),
		.map_rd_addr (map_rd_addr),
		.map_rd_data (map_rd_data)
	);

	pst_map u_map (
		.clk     (clk),
		.wr_en   (map_wr_en),
		.wr_addr (map_wr_addr),
		.wr_data (map_wr_data),
		.rd_en   (map_rd_en),
		.rd_addr (map_rd_addr),
		.rd_data (map_rd_data)
	);

endmodule

// ----- rtl/pst_chk.sv -----
// Port checker for the peer signal table unit, bound to the top level.
// Depends on pst_pkg and the assertion macros header.
`include "peer_signal_table_unit_macros.svh"

module pst_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [pst_pkg::M_TDATA_W-1:0]  m_tdata
);

	// A stalled output word holds.
	`PST_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// An accepted input word leaves the block busy in the cycle after it.
	`PST_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

	// A stored packet carries no tick flags.
	`PST_ASSERT_SAME(a_pkt_no_tick, m_tvalid && m_tdata[0], m_tdata[24:5] == 20'd0)

	// No slot is reported unless the packet was stored.
	`PST_ASSERT_SAME(a_slot_needs_accept, m_tvalid && !m_tdata[0], m_tdata[4:1] == 4'd0)

	// The hug address is zero when no hug candidate is reported.
	`PST_ASSERT_SAME(a_hug_addr_zero, m_tvalid && !m_tdata[8], m_tdata[24:9] == 16'd0)

endmodule

bind peer_signal_table_unit pst_chk u_pst_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- tb/sv/peer_signal_table_unit_tb.sv -----
// Self-checking testbench for peer_signal_table_unit: a directed table followed by
// randomised phases; every output word is checked against the behavioural table
// model or a directed row's own answer. Depends on pst_pkg and the unit's RTL only.
`timescale 1ns / 100ps

module peer_signal_table_unit_tb;
	import pst_pkg::*;

	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
	localparam int PHASES = 12;
	localparam int WORDS_PER_PHASE = 170;
	localparam int OFF_PHASE = 5;
	localparam int PRESSURE_PHASE = 4;
	localparam int POOL_SIZE = 20;
	localparam int LONG_HOLD = 300;
	localparam int DRAIN_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 2 * TABLE_SLOTS + 8;

	typedef struct packed {
		logic [ADDR_W-1:0]       hug_addr;
		logic                    hug_found;
		logic                    unmarked_close;
		logic                    unmarked_in_range;
		logic                    ping_due;
		logic [SLOT_FIELD_W-1:0] slot;
		logic                    accepted;
	} peer_result_t;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t             row;
		logic [KIND_W-1:0]     kind;
		logic [ADDR_W-1:0]     addr;
		logic [ENERGY_W-1:0]   energy;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_value;
		logic                  typed;
		peer_result_t          want;
	} plan_row_t;

	// Fields from the top: hug_addr, four tick flags, slot, accepted.
	localparam peer_result_t NO_ANSWER = '0;
	localparam peer_result_t STORED_SLOT0 = peer_result_t'({16'h0, 4'h0, 4'd0, 1'b1});
	localparam peer_result_t STORED_SLOT1 = peer_result_t'({16'h0, 4'h0, 4'd1, 1'b1});

	localparam int PLAN_ROWS = 37;
	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		'{ROW_ITEM, KIND_SPARE,  16'hFFFF, 8'hFF, REG_ENABLE,  9'd0,   1'b1, NO_ANSWER},
		'{ROW_ITEM, KIND_TICK,   16'h0000, 8'h00, REG_ENABLE,  9'd0,   1'b1, NO_ANSWER},
		'{ROW_ITEM, KIND_PACKET, 16'h0000, 8'h00, REG_ENABLE,  9'd0,   1'b1, STORED_SLOT0},
		'{ROW_ITEM, KIND_PACKET, 16'hFFFF, 8'hFF, REG_ENABLE,  9'd0,   1'b1, STORED_SLOT1},
		'{ROW_ITEM, KIND_MARK,   16'h0400, 8'h81, REG_ENABLE,  9'd0,   1'b0, NO_ANSWER},
		'{ROW_ITEM, KIND_MARK,   16'h0401, 8'h7E, REG_ENABLE,  9'd0,   1'b0, NO_ANSWER},
		'{ROW_ITEM, KIND_MARK,   16'hFFFF, 8'h00, REG_ENABLE,  9'd0,   1'b0, NO_ANSWER},
		'{ROW_ITEM, KIND_MARK,   16'h0000, 8'h00, REG_ENABLE,  9'd0,   1'b0, NO_ANSWER},
		'{ROW_ITEM, KIND_TICK,   16'h0000, 8'h00, REG_ENABLE,  9'd0,   1'b0, NO_ANSWER},
		// A one-tick peer in slot 2 expires, so a later packet for the long-lived
		// address in slot 3 takes slot 2 first, and both slots end up holding it.
		'{ROW_REG,  KIND_PACKET, 16'h0000, 8'h00, REG_TIMEOUT, 9'd1,   1'b0, NO_ANSWER},
		'{ROW_ITEM, KIND_PACKET, 16'h00A5, 8'h5A, REG_ENABLE,  9'd0,   1'b0, NO_ANSWER},
		'{ROW_REG,  KIND_PACKET, 16'h0000, 8'h00, REG_TIMEOUT, 9'd255, 1'b0, NO_ANSWER},
		'{ROW_ITEM, KIND_PACKET, 16'h0123, 8'h40, REG_ENABLE,  9'd0,   1'b0, NO_ANSWER},
		'{ROW_ITEM, KIND_TICK,   16'h0000, 8'h00, REG_ENABLE,  9'd0,   1'b0, NO_ANSWER},
		'{ROW_ITEM, KIND_PACKET, 16'h0123, 8'hC0, REG_ENABLE,  9'd0,   1'b0, NO_ANSWER},
		'{ROW_ITEM, KIND_TICK,   16'h0000, 8'h00, REG_ENABLE,  9'd0,   1'b0, NO_ANSWER},
		'{ROW_REG,  KIND_PACKET, 16'h0000, 8'h00, REG_CLOSE,   9'd0,   1'b0, NO_ANSWER},
		'{ROW_REG,  KIND_PACKET, 16'h0000, 8'h00, REG_HUG,     9'd0,   1'b0, NO_ANSWER},
		'{ROW_REG,  KIND_PACKET, 16'h0000, 8'h00, REG_FAST,    9'd0,   1'b0, NO_ANSWER},
		'{ROW_ITEM, KIND_TICK,   16'h0000, 8'h00, REG_ENABLE,  9'd0,   1'b0, NO_ANSWER},
		'{ROW_REG,  KIND_PACKET, 16'h0000, 8'h00, REG_HUG,     9'd510, 1'b0, NO_ANSWER},
		'{ROW_REG,  KIND_PACKET, 16'h0000, 8'h00, REG_CLOSE,   9'd255, 1'b0, NO_ANSWER},
		'{ROW_REG,  KIND_PACKET, 16'h0000, 8'h00, REG_SLOW,    9'd0,   1'b0, NO_ANSWER},
		'{ROW_REG,  KIND_PACKET, 16'h0000, 8'h00, REG_MID,     9'd126, 1'b0, NO_ANSWER},
		'{ROW_REG,  KIND_PACKET, 16'h0000, 8'h00, REG_FAST,    9'd126, 1'b0, NO_ANSWER},
		'{ROW_ITEM, KIND_TICK,   16'h0000, 8'h00, REG_ENABLE,  9'd0,   1'b0, NO_ANSWER},
		'{ROW_REG,  KIND_PACKET, 16'h0000, 8'h00, REG_SLOW,    9'd126, 1'b0, NO_ANSWER},
		'{ROW_REG,  KIND_PACKET, 16'h0000, 8'h00, REG_MID,     9'd0,   1'b0, NO_ANSWER},
		'{ROW_ITEM, KIND_TICK,   16'h0000, 8'h00, REG_ENABLE,  9'd0,   1'b0, NO_ANSWER},
		'{ROW_REG,  KIND_PACKET, 16'h0000, 8'h00, REG_ENABLE,  9'd0,   1'b0, NO_ANSWER},
		'{ROW_ITEM, KIND_PACKET, 16'h4242, 8'h80, REG_ENABLE,  9'd0,   1'b1, NO_ANSWER},
		'{ROW_ITEM, KIND_TICK,   16'h0000, 8'h00, REG_ENABLE,  9'd0,   1'b1, NO_ANSWER},
		'{ROW_ITEM, KIND_MARK,   16'h0123, 8'h55, REG_ENABLE,  9'd0,   1'b0, NO_ANSWER},
		'{ROW_REG,  KIND_PACKET, 16'h0000, 8'h00, REG_ENABLE,  9'd1,   1'b0, NO_ANSWER},
		'{ROW_ITEM, KIND_PACKET, 16'h0123, 8'h10, REG_ENABLE,  9'd0,   1'b0, NO_ANSWER},
		'{ROW_ITEM, KIND_TICK,   16'h0000, 8'h00, REG_ENABLE,  9'd0,   1'b0, NO_ANSWER},
		'{ROW_ITEM, KIND_SPARE,  16'h0000, 8'h00, REG_ENABLE,  9'd0,   1'b1, NO_ANSWER}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;   // peer_addr[15:0], energy[23:16]
	logic [KIND_W-1:0]     s_tuser;   // kind[1:0]
	logic                  m_tvalid;
	logic                  m_tready;
	// accepted[0], slot[4:1], ping_due[5], unmarked_in_range[6],
	// unmarked_close[7], hug_found[8], hug_addr[24:9], zeros above
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Model of the peer table and its registers.
	bit [ADDR_W-1:0]   slot_addr [TABLE_SLOTS];
	bit [LIFE_W-1:0]   slot_life [TABLE_SLOTS];
	bit [ENERGY_W-1:0] slot_now [TABLE_SLOTS];
	bit [ENERGY_W-1:0] slot_before [TABLE_SLOTS];
	bit [PING_W-1:0]   ping_count;
	bit                contacted [MAP_ENTRIES];
	logic                cur_enable = ENABLE_RST;
	logic [LIFE_W-1:0]   cur_reload = TIMEOUT_RST;
	logic [LEVEL_W-1:0]  cur_hug = HUG_RST;
	logic [ENERGY_W-1:0] cur_close = CLOSE_RST;
	logic [PING_W-1:0]   cur_slow = SLOW_RST;
	logic [PING_W-1:0]   cur_mid = MID_RST;
	logic [PING_W-1:0]   cur_fast = FAST_RST;

	peer_result_t    answers_due [$];
	int              mismatches = 0;
	int              tx_gap_max = 16;
	int              rx_stall_max = 16;
	bit              rx_hold_req = 1'b0;
	logic [ADDR_W-1:0] peer_pool [POOL_SIZE];

	peer_signal_table_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Advances the table model by one input word and returns the answer it calls for.
	function automatic peer_result_t peer_table_answer(input logic [KIND_W-1:0] k,
			input logic [ADDR_W-1:0] a, input logic [ENERGY_W-1:0] e);
		peer_result_t res;
		logic found, live, near, seen, due;
		logic [SLOT_W-1:0] pick, min_slot;
		logic [ENERGY_W-1:0] min_e;
		res = '0;
		found = 1'b0;
		pick = '0;
		min_slot = '0;
		min_e = ENERGY_MAX;
		live = 1'b0;
		near = 1'b0;
		if (k == KIND_PACKET && cur_enable) begin
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				if (!found) begin
					if (slot_addr[i] == a) begin
						found = 1'b1;
						pick = SLOT_W'(i);
					end else if (slot_life[i] == 0) begin
						// An expired slot is reused with its history wiped.
						found = 1'b1;
						pick = SLOT_W'(i);
						slot_now[i] = '0;
					end else if (slot_now[i] < min_e) begin
						min_e = slot_now[i];
						min_slot = SLOT_W'(i);
					end
				end
			end
			if (!found && e > min_e) begin
				found = 1'b1;
				pick = min_slot;
			end
			if (found) begin
				slot_life[pick] = cur_reload;
				slot_addr[pick] = a;
				slot_before[pick] = slot_now[pick];
				slot_now[pick] = e;
				res.accepted = 1'b1;
				res.slot = SLOT_FIELD_W'(pick);
			end
		end else if (k == KIND_TICK && cur_enable) begin
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				if (slot_life[i] != 0) begin
					// Addresses the map cannot hold count as already contacted.
					seen = (slot_addr[i] >= MAP_ENTRIES) ? 1'b1 : contacted[slot_addr[i]];
					slot_life[i] = slot_life[i] - 1'b1;
					live = 1'b1;
					if (!seen)
						res.unmarked_in_range = 1'b1;
					if (slot_now[i] > cur_close) begin
						near = 1'b1;
						if (!seen)
							res.unmarked_close = 1'b1;
					end
				end
				if (!res.hug_found && slot_addr[i] != 0 &&
						({1'b0, slot_now[i]} + {1'b0, slot_before[i]}) > cur_hug) begin
					res.hug_found = 1'b1;
					res.hug_addr = slot_addr[i];
				end
			end
			ping_count = ping_count + 1'b1;
			due = ping_count > cur_slow || (live && ping_count > cur_mid) ||
				(near && ping_count > cur_fast);
			if (due)
				ping_count = '0;
			res.ping_due = due;
		end else if (k == KIND_MARK && a < MAP_ENTRIES) begin
			contacted[a] = 1'b1;
		end
		return res;
	endfunction

	// Either end of the range, a value anywhere in it, or one near the bottom.
	function automatic logic [CFG_DATA_W-1:0] pick_level(input int lo, input int hi);
		case ($urandom_range(0, 3))
			0: return CFG_DATA_W'(lo);
			1: return CFG_DATA_W'(hi);
			2: return CFG_DATA_W'($urandom_range(lo, hi));
			default: return CFG_DATA_W'($urandom_range(lo, lo + (hi - lo) / 16));
		endcase
	endfunction

	function automatic logic [ENERGY_W-1:0] pick_energy();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return ENERGY_MAX;
			default: return ENERGY_W'($urandom);
		endcase
	endfunction

	task automatic send_item(input logic [KIND_W-1:0] k, input logic [ADDR_W-1:0] a,
			input logic [ENERGY_W-1:0] e, input logic typed, input peer_result_t want);
		int gap;
		peer_result_t ans;
		gap = $urandom_range(0, tx_gap_max);
		cfg_valid <= 1'b0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= k;
		s_tdata <= {e, a};
		do @(posedge clk); while (!s_tready);
		ans = peer_table_answer(k, a, e);
		answers_due.push_back(typed ? want : ans);
	endtask

	// Registers change only once every outstanding word has come back.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ENABLE: begin
				cur_enable = value[0];
				// Enabling wipes the table but keeps the ping count and the map.
				if (value[0]) begin
					for (int i = 0; i < TABLE_SLOTS; i++) begin
						slot_addr[i] = '0;
						slot_life[i] = '0;
						slot_now[i] = '0;
						slot_before[i] = '0;
					end
				end
			end
			REG_TIMEOUT: cur_reload = value[LIFE_W-1:0];
			REG_HUG: cur_hug = value[LEVEL_W-1:0];
			REG_CLOSE: cur_close = value[ENERGY_W-1:0];
			REG_SLOW: cur_slow = value[PING_W-1:0];
			REG_MID: cur_mid = value[PING_W-1:0];
			REG_FAST: cur_fast = value[PING_W-1:0];
			default: ;
		endcase
	endtask

	// Receiver: random back-pressure, plus one long hold-off on request.
	initial begin : sink
		int stall;
		peer_result_t want, got;
		m_tready = 1'b0;
		forever begin
			stall = rx_hold_req ? LONG_HOLD : $urandom_range(0, rx_stall_max);
			rx_hold_req = 1'b0;
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (answers_due.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected output word %h", m_tdata);
				mismatches++;
			end else begin
				want = answers_due.pop_front();
				got = peer_result_t'(m_tdata[OUT_FIELDS_W-1:0]);
				if (got !== want || m_tdata[M_TDATA_W-1:OUT_FIELDS_W] !== '0) begin
					if (mismatches < 10)
						$display("output word mismatch: expected %h, got %h", want, m_tdata);
					mismatches++;
				end
			end
		end
	end

	initial begin : watchdog
		#8000000;
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		int words, r, n;
		bit saturate;
		logic [ADDR_W-1:0] base;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = KIND_PACKET;
		cfg_valid = 1'b0;
		cfg_index = REG_ENABLE;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		for (int row = 0; row < PLAN_ROWS; row++) begin
			if (PLAN[row].row == ROW_REG) begin
				wait_idle();
				write_reg(PLAN[row].reg_idx, PLAN[row].reg_value);
			end else begin
				send_item(PLAN[row].kind, PLAN[row].addr, PLAN[row].energy,
					PLAN[row].typed, PLAN[row].want);
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			saturate = (phase % 6 == 3);
			wait_idle();
			if (phase == OFF_PHASE || !cur_enable || saturate || $urandom_range(0, 2) == 0)
				write_reg(REG_ENABLE, (phase == OFF_PHASE) ? 9'd0 : 9'd1);
			write_reg(REG_TIMEOUT, saturate ? 9'd255 : pick_level(1, 255));
			write_reg(REG_HUG, pick_level(0, 510));
			write_reg(REG_CLOSE, pick_level(0, 255));
			write_reg(REG_SLOW, pick_level(0, 126));
			write_reg(REG_MID, pick_level(0, 126));
			write_reg(REG_FAST, pick_level(0, 126));
			tx_gap_max = (phase % 3 == 1) ? 0 : 16;
			rx_stall_max = (phase % 4 == 2) ? 0 : 16;
			if (phase == PRESSURE_PHASE)
				rx_hold_req = 1'b1;
			// Mostly addresses the map can hold, so marks and matches happen often.
			for (int i = 0; i < POOL_SIZE; i++)
				peer_pool[i] = ($urandom_range(0, 3) == 0) ? ADDR_W'($urandom) :
					ADDR_W'($urandom_range(0, MAP_ENTRIES + 40));
			if (saturate) begin
				// Fill every slot at full energy; the three newcomers cannot evict anyone.
				base = ADDR_W'($urandom);
				for (int i = 0; i < TABLE_SLOTS + 2; i++)
					send_item(KIND_PACKET, base + ADDR_W'(i), ENERGY_MAX, 1'b0, NO_ANSWER);
				send_item(KIND_PACKET, base + ADDR_W'(TABLE_SLOTS + 2), ENERGY_MAX - 1'b1,
					1'b0, NO_ANSWER);
				send_item(KIND_TICK, ADDR_W'($urandom), pick_energy(), 1'b0, NO_ANSWER);
			end
			words = (phase == OFF_PHASE) ? 40 : WORDS_PER_PHASE;
			for (int w = 0; w < words; w++) begin
				r = $urandom_range(0, 99);
				if (r < 50)
					send_item(KIND_PACKET, peer_pool[$urandom_range(0, POOL_SIZE - 1)],
						pick_energy(), 1'b0, NO_ANSWER);
				else if (r < 55)
					send_item(KIND_PACKET, ADDR_W'($urandom), pick_energy(), 1'b0, NO_ANSWER);
				else if (r < 80)
					send_item(KIND_TICK, ADDR_W'($urandom), ENERGY_W'($urandom), 1'b0, NO_ANSWER);
				else if (r < 92)
					send_item(KIND_MARK, peer_pool[$urandom_range(0, POOL_SIZE - 1)],
						ENERGY_W'($urandom), 1'b0, NO_ANSWER);
				else if (r < 96)
					send_item(KIND_MARK, ADDR_W'($urandom), ENERGY_W'($urandom), 1'b0, NO_ANSWER);
				else
					send_item(KIND_SPARE, ADDR_W'($urandom), ENERGY_W'($urandom), 1'b0, NO_ANSWER);
			end
		end
		s_tvalid <= 1'b0;

		for (n = 0; n < DRAIN_LIMIT && answers_due.size() != 0; n++) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && answers_due.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
